[rtl/scsi_sense_error_classifier_unit_macros.svh]
// assertion macros shared by the sense error classifier rtl
`ifndef SCSI_SENSE_ERROR_CLASSIFIER_UNIT_MACROS_SVH
`define SCSI_SENSE_ERROR_CLASSIFIER_UNIT_MACROS_SVH

// condition checked in the same cycle as its trigger
`define SSEC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition checked in the cycle after its trigger
`define SSEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssec_pkg.sv]
// types, codes and packing constants of the sense error classifier
`timescale 1ns / 1ps

package ssec_pkg;

    // stream widths
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // adapter error categories
    localparam logic [3:0] CAT_NONE    = 4'd0;
    localparam logic [3:0] CAT_SENSE   = 4'd1;
    localparam logic [3:0] CAT_SHORT   = 4'd2;
    localparam logic [3:0] CAT_BUSY    = 4'd3;
    localparam logic [3:0] CAT_TIMEOUT = 4'd4;
    localparam logic [3:0] CAT_RESET   = 4'd7;

    // sense response codes
    localparam logic [6:0] RC_CURRENT  = 7'h70;
    localparam logic [6:0] RC_DEFERRED = 7'h71;

    // sense keys
    localparam logic [3:0] SK_NO_SENSE   = 4'h0;
    localparam logic [3:0] SK_RECOVERED  = 4'h1;
    localparam logic [3:0] SK_NOT_READY  = 4'h2;
    localparam logic [3:0] SK_ILLEGAL    = 4'h5;
    localparam logic [3:0] SK_UNIT_ATTN  = 4'h6;
    localparam logic [3:0] SK_DATA_PROT  = 4'h7;
    localparam logic [3:0] SK_BLANK      = 4'h8;
    localparam logic [3:0] SK_ABORTED    = 4'hB;
    localparam logic [3:0] SK_EQUAL      = 4'hC;
    localparam logic [3:0] SK_OVERFLOW   = 4'hD;

    // additional sense codes
    localparam logic [7:0] ASC_NO_MEDIUM   = 8'h3A;
    localparam logic [7:0] ASC_LUN_UNSUPP  = 8'h25;
    localparam logic [7:0] ASC_POWER_RESET = 8'h29;
    localparam logic [7:0] ASCQ_ZERO       = 8'h00;

    // control flag bit positions
    localparam int CF_IGN_NOT_READY = 0;
    localparam int CF_IGN_ILLEGAL   = 1;
    localparam int CF_DISCOVERY     = 2;
    localparam int CF_SILENT        = 3;
    localparam int CF_IGN_MEDIA_CHG = 4;
    localparam int CF_NOSLEEP       = 5;

    typedef enum logic [2:0] {
        OC_OK    = 3'd0,
        OC_RETRY = 3'd1,
        OC_EIO   = 3'd2,
        OC_NODEV = 3'd3,
        OC_INVAL = 3'd4,
        OC_ROFS  = 3'd5,
        OC_NOSPC = 3'd6
    } t_outcome;

    typedef struct packed {
        logic [3:0]  error_category;
        logic [6:0]  response_code;
        logic        info_valid;
        logic [3:0]  sense_key;
        logic [7:0]  asc;
        logic [7:0]  ascq;
        logic [5:0]  ctl_flags;
        logic        poll_mode;
        logic [7:0]  retries;
        logic [31:0] residual;
        logic [31:0] data_length;
    } t_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  retries_left;
        logic        clear_media_loaded;
        logic [31:0] residual_out;
    } t_result;

endpackage

[rtl/ssec_in_reg.sv]
// input register stage: captures and unpacks one completion transaction
`timescale 1ns / 1ps

module ssec_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ssec_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [ssec_pkg::S_TUSER_W-1:0] i_tuser,
    input  logic                          i_take,
    output logic                          o_valid,
    output ssec_pkg::t_item               o_item
);

    logic            r_valid;
    ssec_pkg::t_item r_item;
    ssec_pkg::t_item n_item;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_item.error_category = i_tuser[3:0];
        n_item.response_code  = i_tdata[6:0];
        n_item.info_valid     = i_tdata[7];
        n_item.sense_key      = i_tdata[11:8];
        n_item.asc            = i_tdata[19:12];
        n_item.ascq           = i_tdata[27:20];
        n_item.ctl_flags      = i_tdata[33:28];
        n_item.poll_mode      = i_tdata[34];
        n_item.retries        = i_tdata[42:35];
        n_item.residual       = i_tdata[74:43];
        n_item.data_length    = i_tdata[106:75];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/ssec_classify.sv]
// decision logic: maps one completion to outcome, retries, media flag and residual
`timescale 1ns / 1ps

module ssec_classify (
    input  ssec_pkg::t_item   i_item,
    input  logic              i_removable_media,
    output ssec_pkg::t_result o_result
);

    ssec_pkg::t_outcome oc;
    logic               restart;
    logic               clear;
    logic [31:0]        resid;
    logic               extended;
    logic               busy_no_wait;

    assign extended = (i_item.response_code == ssec_pkg::RC_CURRENT) ||
                      (i_item.response_code == ssec_pkg::RC_DEFERRED);

    assign busy_no_wait = (i_item.retries != 8'd0) && !i_item.poll_mode &&
                          (i_item.ctl_flags[ssec_pkg::CF_NOSLEEP] ||
                           i_item.ctl_flags[ssec_pkg::CF_DISCOVERY]);

    always_comb begin
        oc      = ssec_pkg::OC_EIO;
        restart = 1'b0;
        clear   = 1'b0;
        resid   = i_item.residual;
        case (i_item.error_category)
            ssec_pkg::CAT_NONE: begin
                oc = ssec_pkg::OC_OK;
            end
            ssec_pkg::CAT_SENSE, ssec_pkg::CAT_SHORT: begin
                if (extended) begin
                    case (i_item.sense_key)
                        ssec_pkg::SK_NO_SENSE, ssec_pkg::SK_RECOVERED: begin
                            // full-length short read with nothing wrong
                            if ((i_item.residual == i_item.data_length) &&
                                (i_item.data_length != 32'd0)) begin
                                resid = 32'd0;
                            end
                            oc = ssec_pkg::OC_OK;
                        end
                        ssec_pkg::SK_EQUAL, ssec_pkg::SK_BLANK: begin
                            oc = ssec_pkg::OC_OK;
                        end
                        ssec_pkg::SK_NOT_READY: begin
                            clear = i_removable_media;
                            if (i_item.ctl_flags[ssec_pkg::CF_IGN_NOT_READY]) begin
                                oc = ssec_pkg::OC_OK;
                            end else if ((i_item.asc == ssec_pkg::ASC_NO_MEDIUM) &&
                                         (i_item.ascq == ssec_pkg::ASCQ_ZERO)) begin
                                oc = ssec_pkg::OC_NODEV;
                            end
                        end
                        ssec_pkg::SK_ILLEGAL: begin
                            if (i_item.ctl_flags[ssec_pkg::CF_IGN_ILLEGAL]) begin
                                oc = ssec_pkg::OC_OK;
                            end else if (i_item.ctl_flags[ssec_pkg::CF_DISCOVERY] &&
                                         (i_item.asc == ssec_pkg::ASC_LUN_UNSUPP) &&
                                         (i_item.ascq == ssec_pkg::ASCQ_ZERO)) begin
                                oc = ssec_pkg::OC_INVAL;
                            end else if (!i_item.ctl_flags[ssec_pkg::CF_SILENT]) begin
                                oc = ssec_pkg::OC_INVAL;
                            end
                        end
                        ssec_pkg::SK_UNIT_ATTN: begin
                            if ((i_item.asc == ssec_pkg::ASC_POWER_RESET) &&
                                (i_item.ascq == ssec_pkg::ASCQ_ZERO)) begin
                                restart = 1'b1;
                            end else begin
                                clear = i_removable_media;
                                if (i_item.ctl_flags[ssec_pkg::CF_IGN_MEDIA_CHG] ||
                                    !i_removable_media) begin
                                    restart = 1'b1;
                                end
                            end
                        end
                        ssec_pkg::SK_DATA_PROT: begin
                            oc = ssec_pkg::OC_ROFS;
                        end
                        ssec_pkg::SK_ABORTED: begin
                            restart = 1'b1;
                        end
                        ssec_pkg::SK_OVERFLOW: begin
                            oc = ssec_pkg::OC_NOSPC;
                        end
                        default: begin
                            oc = ssec_pkg::OC_EIO;
                        end
                    endcase
                end
            end
            ssec_pkg::CAT_BUSY: begin
                restart = !busy_no_wait;
            end
            ssec_pkg::CAT_TIMEOUT, ssec_pkg::CAT_RESET: begin
                restart = 1'b1;
            end
            default: begin
                oc = ssec_pkg::OC_EIO;
            end
        endcase

        o_result.retries_left = i_item.retries;
        if (restart) begin
            if (i_item.retries != 8'd0) begin
                oc                    = ssec_pkg::OC_RETRY;
                o_result.retries_left = i_item.retries - 8'd1;
            end else begin
                oc = ssec_pkg::OC_EIO;
            end
        end
        o_result.outcome            = oc;
        o_result.clear_media_loaded = clear;
        o_result.residual_out       = resid;
    end

endmodule

[rtl/ssec_out_reg.sv]
// result register stage: holds one classified transaction for the master side
`timescale 1ns / 1ps

module ssec_out_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  ssec_pkg::t_result              i_result,
    output logic                           o_load,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ssec_pkg::M_TDATA_W-1:0] o_tdata,
    output logic [ssec_pkg::M_TUSER_W-1:0] o_tuser
);

    logic              r_valid;
    ssec_pkg::t_result r_result;

    assign o_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
        if (o_load && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_tdata = {7'd0, r_result.residual_out, r_result.clear_media_loaded,
                      r_result.retries_left};
    assign o_tuser = r_result.outcome;

endmodule

[rtl/scsi_sense_error_classifier_unit.sv]
// top level of the scsi sense error classifier
`timescale 1ns / 1ps
//
//  channel   direction  payload                                   accepted when
//  s_axis    in         completion: category + sense + counts     tvalid && tready
//  m_axis    out        outcome, retries left, media flag, resid  tvalid && tready
//  cfg       in         removable_media bit                       i_cfg_we
//
//  two-stage path: input register -> decision logic -> result register
//  one transaction per cycle sustained while m_axis does not stall
//  the rate is set by the single-pass decision logic between the two registers
//  reset (i_rst_n low, synchronous) empties both stages and clears removable_media
//  a stall on m_axis backs up through the result register into the input register;
//  s_axis_tready falls only when both stages hold a transaction and m_axis stalls

module scsi_sense_error_classifier_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    // completion input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // response_code[6:0], info_valid[7], sense_key[11:8], asc[19:12], ascq[27:20],
    // ctl_flags[33:28], poll_mode[34], retries[42:35], residual[74:43],
    // data_length[106:75], zero fill[111:107]
    input  logic [ssec_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // error_category[3:0]
    input  logic [ssec_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // classification output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // retries_left[7:0], clear_media_loaded[8], residual_out[40:9], zero fill[47:41]
    output logic [ssec_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // outcome[2:0]
    output logic [ssec_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    `include "scsi_sense_error_classifier_unit_macros.svh"

    // removable media setting, to be written only while the block is idle; not enforced here
    logic r_removable_media;

    logic              item_valid;
    ssec_pkg::t_item   item;
    ssec_pkg::t_result result;
    logic              out_load;

    // terms watched by the assertions
    logic              out_clear;
    logic              out_retry;
    logic              in_take;
    logic              in_stall;
    logic              stage_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_removable_media <= 1'b0;
        end else if (i_cfg_we) begin
            r_removable_media <= i_cfg_wdata;
        end
    end

    // input stage moves forward whenever the result register can load
    ssec_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .i_take  (out_load),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // single-pass decision on the registered transaction
    ssec_classify u_classify (
        .i_item            (item),
        .i_removable_media (r_removable_media),
        .o_result          (result)
    );

    // result register doubles as the skid stage toward m_axis
    ssec_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_result (result),
        .o_load   (out_load),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    assign out_clear  = m_axis_tvalid && m_axis_tdata[8];
    assign out_retry  = m_axis_tvalid && (m_axis_tuser == ssec_pkg::OC_RETRY);
    assign in_take    = s_axis_tvalid && s_axis_tready;
    assign in_stall   = item_valid && !out_load;
    assign stage_room = !item_valid || out_load;

    // media-loaded clearing only ever comes from a removable device
    `SSEC_ASSERT_SAME(a_clear_removable, out_clear, r_removable_media, "clear on fixed media")

    // a retry always consumes one of at least one remaining retries
    `SSEC_ASSERT_SAME(a_retry_sane, out_retry, m_axis_tdata[7:0] != 8'hFF, "retry with none left")

    // a held input transaction is neither lost nor altered
    `SSEC_ASSERT_NEXT(a_in_hold, in_stall, item_valid && $stable(item), "stalled input lost")

    // input accepted only when the input stage is free or draining
    `SSEC_ASSERT_SAME(a_accept_room, in_take, stage_room, "input accepted over full stage")

endmodule
